@@ rtl/cu_pkg.sv @@
// Shared types, constants and tables for the combination unranker.
// Used by every module of the block but the checker; depends on nothing else.
package cu_pkg;

  // Largest accepted set size.
  localparam int unsigned MAX_ELEMENTS = 32;

  localparam int unsigned SIZE_W  = 6;
  localparam int unsigned RANK_W  = 30;
  localparam int unsigned ELEM_W  = 5;
  localparam int unsigned PROD_W  = RANK_W + SIZE_W;
  localparam int unsigned SHIFT_W = 3;

  // One accepted request after classification.
  typedef struct packed {
    logic [SIZE_W-1:0] total;
    logic [SIZE_W-1:0] pick;
    logic [RANK_W-1:0] rank;
    logic              bad_size;
  } cu_item_t;

  // Request to the exact multiply-divide unit: val * mul / div.
  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] val;
    logic [SIZE_W-1:0] mul;
    logic [SIZE_W-1:0] div;
  } cu_md_req_t;

  typedef struct packed {
    logic              done;
    logic [RANK_W-1:0] quot;
  } cu_md_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BINOM,
    ST_BWAIT,
    ST_CHECK,
    ST_IWAIT,
    ST_DECIDE,
    ST_WWAIT,
    ST_ERROR
  } cu_state_e;

  typedef logic [31:0][RANK_W-1:0] cu_inv_tab_t;

  // Inverses of the odd numbers modulo 2^RANK_W, found by Newton steps.
  // Entry i holds the inverse of (i | 1).
  function automatic cu_inv_tab_t build_inv_tab();
    cu_inv_tab_t tab;
    logic [31:0] d;
    logic [31:0] x;
    for (int i = 0; i < 32; i++) begin
      d = 32'(i) | 32'd1;
      x = d;
      for (int s = 0; s < 5; s++) begin
        x = x * (32'd2 - d * x);
      end
      tab[i] = x[RANK_W-1:0];
    end
    return tab;
  endfunction

  localparam cu_inv_tab_t INV_TAB = build_inv_tab();

endpackage

@@ rtl/cu_front.sv @@
// Front end: takes stream requests, unpacks and screens the sizes.
// Depends on cu_pkg; feeds the request queue.
module cu_front (
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [47:0]      s_axis_tdata_i,
  output logic             push_o,
  output cu_pkg::cu_item_t item_o,
  input  logic             full_i
);

  logic [cu_pkg::SIZE_W-1:0] total;
  logic [cu_pkg::SIZE_W-1:0] pick;

  assign total = s_axis_tdata_i[5:0];
  assign pick  = s_axis_tdata_i[11:6];

  // Size screening: empty subsets, subsets larger than the set, oversize sets.
  always_comb begin
    item_o.total    = total;
    item_o.pick     = pick;
    item_o.rank     = s_axis_tdata_i[41:12];
    item_o.bad_size = (pick == '0) || (pick > total) ||
                      (total > cu_pkg::SIZE_W'(cu_pkg::MAX_ELEMENTS));
  end

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

endmodule

@@ rtl/cu_fifo.sv @@
// Two-entry queue between the front end and the unranking engine.
// Depends on cu_pkg for the item type.
module cu_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cu_pkg::cu_item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cu_pkg::cu_item_t item_o
);

  cu_pkg::cu_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

@@ rtl/cu_muldiv.sv @@
// Two-stage exact multiply-divide: quotient of val * mul by div, where the
// division is known to leave no remainder. Depends on cu_pkg.
module cu_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cu_pkg::cu_md_req_t req_i,
  output cu_pkg::cu_md_rsp_t rsp_o
);

  logic [cu_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic [cu_pkg::SHIFT_W-1:0] shift_q, shift_d;
  logic [cu_pkg::RANK_W-1:0]  inv_q, inv_d;
  logic [cu_pkg::RANK_W-1:0]  quot_q, quot_d;
  logic                       stage1_q, done_q;
  logic [cu_pkg::SIZE_W-1:0]  odd;
  logic [cu_pkg::PROD_W-1:0]  shifted;
  logic [2*cu_pkg::RANK_W-1:0] full_prod;

  // Stage one: product, and the divisor split into a power of two and an odd
  // part whose inverse comes from the table.
  always_comb begin
    prod_d = cu_pkg::PROD_W'(req_i.val) * cu_pkg::PROD_W'(req_i.mul);
    priority if (req_i.div[0]) shift_d = 3'd0;
    else if (req_i.div[1]) shift_d = 3'd1;
    else if (req_i.div[2]) shift_d = 3'd2;
    else if (req_i.div[3]) shift_d = 3'd3;
    else if (req_i.div[4]) shift_d = 3'd4;
    else shift_d = 3'd5;
    odd   = req_i.div >> shift_d;
    inv_d = cu_pkg::INV_TAB[odd[4:0]];
  end

  // Stage two: exact quotient as a product with the odd inverse.
  always_comb begin
    shifted   = prod_q >> shift_q;
    full_prod = shifted[cu_pkg::RANK_W-1:0] * inv_q;
    quot_d    = full_prod[cu_pkg::RANK_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= req_i.start;
      done_q   <= stage1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    shift_q <= shift_d;
    inv_q   <= inv_d;
    quot_q  <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/cu_engine.sv @@
// Back end: computes the binomial, checks the rank and walks the elements,
// writing results into the output register. Depends on cu_pkg, cu_muldiv.
module cu_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cu_pkg::cu_item_t item_i,
  output logic             pop_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o
);

  cu_pkg::cu_state_e state_q, state_d;
  logic [cu_pkg::SIZE_W-1:0] total_q, total_d;
  logic [cu_pkg::SIZE_W-1:0] pick_q, pick_d;
  logic [cu_pkg::SIZE_W-1:0] low_q, low_d;
  logic [cu_pkg::SIZE_W-1:0] step_q, step_d;
  logic [cu_pkg::SIZE_W-1:0] rem_q, rem_d;
  logic [cu_pkg::SIZE_W-1:0] left_q, left_d;
  logic [cu_pkg::ELEM_W-1:0] elem_q, elem_d;
  logic [cu_pkg::RANK_W-1:0] rank_q, rank_d;
  logic [cu_pkg::RANK_W-1:0] coef_q, coef_d;
  logic                      out_valid_q, out_valid_d;
  logic [cu_pkg::ELEM_W-1:0] out_elem_q, out_elem_d;
  logic                      out_last_q, out_last_d;
  logic                      out_err_q, out_err_d;
  logic                      out_free;
  logic [cu_pkg::SIZE_W-1:0] other;
  cu_pkg::cu_md_req_t        md_req;
  cu_pkg::cu_md_rsp_t        md_rsp;

  cu_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign other    = item_i.total - item_i.pick;

  // Sequencer for binomial, rank check and element walk.
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    pick_d      = pick_q;
    low_d       = low_q;
    step_d      = step_q;
    rem_d       = rem_q;
    left_d      = left_q;
    elem_d      = elem_q;
    rank_d      = rank_q;
    coef_d      = coef_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_elem_d  = out_elem_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    pop_o       = 1'b0;
    md_req      = '0;

    unique case (state_q)
      cu_pkg::ST_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          total_d = item_i.total;
          pick_d  = item_i.pick;
          rank_d  = item_i.rank;
          low_d   = (item_i.pick < other) ? item_i.pick : other;
          step_d  = cu_pkg::SIZE_W'(1);
          coef_d  = cu_pkg::RANK_W'(1);
          if (item_i.bad_size) begin
            state_d = cu_pkg::ST_ERROR;
          end else if (item_i.pick == item_i.total) begin
            state_d = cu_pkg::ST_CHECK;
          end else begin
            state_d = cu_pkg::ST_BINOM;
          end
        end
      end
      cu_pkg::ST_BINOM: begin
        md_req.start = 1'b1;
        md_req.val   = coef_q;
        md_req.mul   = total_q - low_q + step_q;
        md_req.div   = step_q;
        state_d      = cu_pkg::ST_BWAIT;
      end
      cu_pkg::ST_BWAIT: begin
        if (md_rsp.done) begin
          coef_d = md_rsp.quot;
          if (step_q == low_q) begin
            state_d = cu_pkg::ST_CHECK;
          end else begin
            step_d  = step_q + cu_pkg::SIZE_W'(1);
            state_d = cu_pkg::ST_BINOM;
          end
        end
      end
      cu_pkg::ST_CHECK: begin
        if (rank_q >= coef_q) begin
          state_d = cu_pkg::ST_ERROR;
        end else begin
          // Count of subsets holding the first element: C(m,n) * n / m.
          md_req.start = 1'b1;
          md_req.val   = coef_q;
          md_req.mul   = pick_q;
          md_req.div   = total_q;
          rem_d        = total_q;
          left_d       = pick_q;
          elem_d       = '0;
          state_d      = cu_pkg::ST_IWAIT;
        end
      end
      cu_pkg::ST_IWAIT, cu_pkg::ST_WWAIT: begin
        if (md_rsp.done) begin
          coef_d  = md_rsp.quot;
          state_d = cu_pkg::ST_DECIDE;
        end
      end
      cu_pkg::ST_DECIDE: begin
        if (rank_q < coef_q) begin
          // Take this element.
          if (out_free) begin
            out_valid_d = 1'b1;
            out_elem_d  = elem_q;
            out_last_d  = (left_q == cu_pkg::SIZE_W'(1));
            out_err_d   = 1'b0;
            if (left_q == cu_pkg::SIZE_W'(1)) begin
              state_d = cu_pkg::ST_IDLE;
            end else begin
              md_req.start = 1'b1;
              md_req.val   = coef_q;
              md_req.mul   = left_q - cu_pkg::SIZE_W'(1);
              md_req.div   = rem_q - cu_pkg::SIZE_W'(1);
              left_d       = left_q - cu_pkg::SIZE_W'(1);
              rem_d        = rem_q - cu_pkg::SIZE_W'(1);
              elem_d       = elem_q + cu_pkg::ELEM_W'(1);
              state_d      = cu_pkg::ST_WWAIT;
            end
          end
        end else begin
          // Skip this element.
          md_req.start = 1'b1;
          md_req.val   = coef_q;
          md_req.mul   = rem_q - left_q;
          md_req.div   = rem_q - cu_pkg::SIZE_W'(1);
          rank_d       = rank_q - coef_q;
          rem_d        = rem_q - cu_pkg::SIZE_W'(1);
          elem_d       = elem_q + cu_pkg::ELEM_W'(1);
          state_d      = cu_pkg::ST_WWAIT;
        end
      end
      cu_pkg::ST_ERROR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_elem_d  = '0;
          out_last_d  = 1'b1;
          out_err_d   = 1'b1;
          state_d     = cu_pkg::ST_IDLE;
        end
      end
      default: state_d = cu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q    <= total_d;
    pick_q     <= pick_d;
    low_q      <= low_d;
    step_q     <= step_d;
    rem_q      <= rem_d;
    left_q     <= left_d;
    elem_q     <= elem_d;
    rank_q     <= rank_d;
    coef_q     <= coef_d;
    out_elem_q <= out_elem_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_elem_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

endmodule

@@ rtl/combination_unranker.sv @@
// Top level of the lexicographic combination unranker.
// Depends on cu_pkg, cu_front, cu_fifo and cu_engine.
//
// Each request carries a set size m, a subset size n and a rank; the block
// returns the indices of the rank-th n-subset of {0..m-1} in lexicographic
// order, one ascending index per result, tlast on the final one. Bad sizes
// (n of zero, n above m, m above 32) or a rank not below C(m,n) give one
// result with element 0, tuser and tlast set. A request first builds the
// binomial, then the first coefficient, then one coefficient per element
// visited up to the last chosen one; every coefficient update passes
// through the two-stage exact multiply-divide unit.
// A two-entry queue lets new requests be taken while one is being worked.
module combination_unranker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // total_elements[5:0], subset_size[11:6], rank[41:12]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // element[4:0]
  output logic        m_axis_tlast_o,  // last
  output logic        m_axis_tuser_o   // error
);

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  cu_pkg::cu_item_t in_item;
  cu_pkg::cu_item_t q_item;

  cu_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .item_o          (in_item),
    .full_i          (full)
  );

  cu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cu_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .item_i          (q_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

@@ rtl/cu_checker.sv @@
// Port-level checks for the combination unranker, bound to the top level.
// Depends on combination_unranker's port list only.
module cu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  logic       out_acc;
  logic [7:0] prev_elem_q;
  logic       in_run_q;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Track the last accepted index and whether a run is still open.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_elem_q <= '0;
      in_run_q    <= 1'b0;
    end else if (out_acc) begin
      prev_elem_q <= m_axis_tdata_o;
      in_run_q    <= !m_axis_tlast_o;
    end
  end

  // An error result always closes its run.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("error result without tlast");

  // An error result carries element zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'd0)
    else $error("error result with nonzero element");

  // Within a run the indices rise strictly.
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && in_run_q |-> m_axis_tdata_o > prev_elem_q)
    else $error("indices within a run do not rise");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
      $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind combination_unranker cu_checker u_cu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
